// File: rtl/core/pfc_pkg.sv
`timescale 1ns / 1ps

package pfc_pkg;

	localparam int COORD_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int ROT_FRAC   = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROT_ROW_X      = 3'd0,
		CFG_ROT_ROW_Y      = 3'd1,
		CFG_ROT_ROW_Z      = 3'd2,
		CFG_SHIFT_X        = 3'd3,
		CFG_SHIFT_Y        = 3'd4,
		CFG_SHIFT_Z        = 3'd5,
		CFG_RANGE_LIMIT_SQ = 3'd6,
		CFG_COS_HALF_FOV   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic                      in_view;
		logic signed [COORD_W-1:0] kept_x;
		logic signed [COORD_W-1:0] kept_y;
		logic signed [COORD_W-1:0] kept_z;
	} result_t;

endpackage

// File: rtl/core/point_fov_cull.sv
`timescale 1ns / 1ps

// Field-of-view crop of map points. Each point is rotated (Q1.14) and shifted into the
// sensor frame, then kept when its squared range is within range_limit_sq and its bearing
// lies within half the view angle. One point enters per clock while point_stall is low. The
// seven-stage pipeline runs rotate, round, translate and saturate, square, range check and
// split products, recombine and compare. Back pressure on
// result_stall holds each stage only while the stage after it is full, so bubbles close up.
// Configuration writes take effect on the next clock and must happen with the pipeline empty.
module point_fov_cull import pfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  point_valid,
	output logic                  point_stall,
	input  point_t                point,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result
);

	localparam logic signed [41:0] RND_HALF = 42'sd8192;
	localparam logic signed [32:0] SAT_HI   = 33'sd33554432;
	localparam logic signed [32:0] SAT_LO   = -33'sd33554432;
	localparam logic signed [15:0] COS_HI   = 16'sd16384;
	localparam logic signed [15:0] COS_LO   = -16'sd16384;
	localparam logic [28:0]        Q_ONE_SQ = 29'h1000_0000;

	// configuration registers
	logic [47:0]        rot_q [3];
	logic signed [31:0] shift_q [3];
	logic [47:0]        range_q;
	logic signed [15:0] cos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]   <= 48'h0000_0000_4000;
			rot_q[1]   <= 48'h0000_4000_0000;
			rot_q[2]   <= 48'h4000_0000_0000;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
			range_q    <= 48'd10000000000;
			cos_q      <= 16'hC000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROT_ROW_X:      rot_q[0]   <= cfg_data;
				CFG_ROT_ROW_Y:      rot_q[1]   <= cfg_data;
				CFG_ROT_ROW_Z:      rot_q[2]   <= cfg_data;
				CFG_SHIFT_X:        shift_q[0] <= cfg_data[31:0];
				CFG_SHIFT_Y:        shift_q[1] <= cfg_data[31:0];
				CFG_SHIFT_Z:        shift_q[2] <= cfg_data[31:0];
				CFG_RANGE_LIMIT_SQ: range_q    <= cfg_data;
				CFG_COS_HALF_FOV:   cos_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [7:1] adv;

	always_comb begin
		adv[7] = !vld_s7 || !result_stall;
		adv[6] = !vld_s6 || adv[7];
		adv[5] = !vld_s5 || adv[6];
		adv[4] = !vld_s4 || adv[5];
		adv[3] = !vld_s3 || adv[4];
		adv[2] = !vld_s2 || adv[3];
		adv[1] = !vld_s1 || adv[2];
	end

	assign point_stall = !adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= point_valid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			if (adv[6]) vld_s6 <= vld_s5;
			if (adv[7]) vld_s7 <= vld_s6;
		end
	end

	// stage 1: rotation products
	logic signed [COORD_W-1:0] coord [3];
	point_t                    pt_s1;
	logic signed [39:0]        prod_s1 [3][3];

	always_comb begin
		coord[0] = point.point_x;
		coord[1] = point.point_y;
		coord[2] = point.point_z;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pt_s1 <= point;
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[j][k] <= $signed(rot_q[j][16*k +: 16]) * coord[k];
				end
			end
		end
	end

	// stage 2: row sums, round to mm
	logic signed [41:0] acc [3];
	point_t             pt_s2;
	logic signed [27:0] rnd_s2 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc[j] = 42'(prod_s1[j][0]) + 42'(prod_s1[j][1]) + 42'(prod_s1[j][2]) + RND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pt_s2 <= pt_s1;
			for (int j = 0; j < 3; j++) begin
				rnd_s2[j] <= acc[j][41:ROT_FRAC];
			end
		end
	end

	// stage 3: translate and saturate
	logic signed [32:0] moved [3];
	point_t             pt_s3;
	logic signed [26:0] t_s3 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			moved[j] = 33'(rnd_s2[j]) + 33'(shift_q[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			pt_s3 <= pt_s2;
			for (int j = 0; j < 3; j++) begin
				if (moved[j] > SAT_HI) begin
					t_s3[j] <= SAT_HI[26:0];
				end else if (moved[j] < SAT_LO) begin
					t_s3[j] <= SAT_LO[26:0];
				end else begin
					t_s3[j] <= moved[j][26:0];
				end
			end
		end
	end

	// stage 4: squares, cosine terms
	logic signed [53:0] sq_full [3];
	logic signed [15:0] c_clamp;
	logic [14:0]        c_mag;
	logic [29:0]        cc_full;
	point_t             pt_s4;
	logic [50:0]        sq_s4 [3];
	logic [28:0]        cc_s4;
	logic [28:0]        rest_s4;
	logic               xneg_s4;
	logic               cneg_s4;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sq_full[j] = t_s3[j] * t_s3[j];
		end
		if (cos_q > COS_HI) begin
			c_clamp = COS_HI;
		end else if (cos_q < COS_LO) begin
			c_clamp = COS_LO;
		end else begin
			c_clamp = cos_q;
		end
		c_mag   = c_clamp[15] ? 15'(-c_clamp) : c_clamp[14:0];
		cc_full = c_mag * c_mag;
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			pt_s4 <= pt_s3;
			for (int j = 0; j < 3; j++) begin
				sq_s4[j] <= sq_full[j][50:0];
			end
			cc_s4   <= cc_full[28:0];
			rest_s4 <= Q_ONE_SQ - cc_full[28:0];
			xneg_s4 <= t_s3[0][26];
			cneg_s4 <= cos_q[15];
		end
	end

	// stage 5: range check, split bearing products
	logic [51:0] dist_sum;
	point_t      pt_s5;
	logic        in_range_s5;
	logic        xneg_s5;
	logic        cneg_s5;
	logic [53:0] pxh_s5;
	logic [54:0] pxl_s5;
	logic [53:0] pyh_s5;
	logic [54:0] pyl_s5;

	assign dist_sum = 52'(sq_s4[0]) + 52'(sq_s4[1]) + 52'(sq_s4[2]);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			pt_s5       <= pt_s4;
			in_range_s5 <= dist_sum <= {4'b0, range_q};
			xneg_s5     <= xneg_s4;
			cneg_s5     <= cneg_s4;
			pxh_s5      <= sq_s4[0][50:26] * rest_s4;
			pxl_s5      <= sq_s4[0][25:0] * rest_s4;
			pyh_s5      <= sq_s4[1][50:26] * cc_s4;
			pyl_s5      <= sq_s4[1][25:0] * cc_s4;
		end
	end

	// stage 6: recombine x^2*(1-c^2) and c^2*y^2
	point_t      pt_s6;
	logic        in_range_s6;
	logic        xneg_s6;
	logic        cneg_s6;
	logic [78:0] lhs_s6;
	logic [78:0] rhs_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			pt_s6       <= pt_s5;
			in_range_s6 <= in_range_s5;
			xneg_s6     <= xneg_s5;
			cneg_s6     <= cneg_s5;
			lhs_s6      <= 79'({pxh_s5, 26'b0}) + 79'(pxl_s5);
			rhs_s6      <= 79'({pyh_s5, 26'b0}) + 79'(pyl_s5);
		end
	end

	// stage 7: bearing decision, output register
	logic    in_angle;
	result_t res_s7;

	always_comb begin
		if (cneg_s6) begin
			in_angle = !xneg_s6 || (lhs_s6 <= rhs_s6);
		end else begin
			in_angle = !xneg_s6 && (lhs_s6 >= rhs_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			res_s7.in_view <= in_range_s6 && in_angle;
			res_s7.kept_x  <= pt_s6.point_x;
			res_s7.kept_y  <= pt_s6.point_y;
			res_s7.kept_z  <= pt_s6.point_z;
		end
	end

	assign result_valid = vld_s7;
	assign result       = res_s7;

`ifndef SYNTHESIS
	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> vld_s1 && result_valid && result_stall)
		else $error("input stalled while output side free");

	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && adv[7] |=> vld_s7)
		else $error("transaction lost at output stage");

	a_out_of_range_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && adv[7] && !in_range_s6 |=> !result.in_view)
		else $error("out of range point flagged in view");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall |=> vld_s1)
		else $error("accepted transaction missing in first stage");
`endif

endmodule

// File: test/tb_point_fov_cull.sv
`timescale 1ns / 1ps

module tb_point_fov_cull import pfc_pkg::*;;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_POINTS   = 250;
	localparam int NUM_PHASES     = 6;
	localparam longint COORD_SAT  = 64'sd33554432;
	localparam longint Q_ONE      = 64'sd16384;

	typedef logic [CFG_DATA_W-1:0] reg_set_t [8];

	class fov_scoreboard;
		logic [47:0]        rot [3];
		logic signed [31:0] shift [3];
		logic [47:0]        range_sq;
		logic signed [15:0] cos_half;
		result_t            expected_q [$];
		int                 errors;

		function new();
			rot[0] = 48'd16384;
			rot[1] = 48'd16384 << 16;
			rot[2] = 48'd16384 << 32;
			foreach (shift[i]) shift[i] = '0;
			range_sq = 48'd10000000000;
			cos_half = -16'sd16384;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_ROT_ROW_X:      rot[0] = d;
				CFG_ROT_ROW_Y:      rot[1] = d;
				CFG_ROT_ROW_Z:      rot[2] = d;
				CFG_SHIFT_X:        shift[0] = d[31:0];
				CFG_SHIFT_Y:        shift[1] = d[31:0];
				CFG_SHIFT_Z:        shift[2] = d[31:0];
				CFG_RANGE_LIMIT_SQ: range_sq = d;
				CFG_COS_HALF_FOV:   cos_half = d[15:0];
				default: ;
			endcase
		endfunction

		function result_t cull_point(point_t p);
			longint       pt [3];
			longint       axis [3];
			longint       sum;
			longint       c;
			logic [63:0]  mag [3];
			logic [63:0]  dist_sq;
			logic [63:0]  cc;
			logic [63:0]  rest;
			logic [127:0] xx;
			logic [127:0] yy;
			logic [127:0] lhs;
			logic [127:0] rhs;
			logic         in_range;
			logic         in_angle;
			result_t      r;
			pt[0] = p.point_x;
			pt[1] = p.point_y;
			pt[2] = p.point_z;
			for (int a = 0; a < 3; a++) begin
				sum = 0;
				for (int k = 0; k < 3; k++)
					sum += longint'($signed(rot[a][16*k +: 16])) * pt[k];
				sum = (sum + 64'sd8192) >>> 14;
				sum += shift[a];
				if (sum > COORD_SAT)
					sum = COORD_SAT;
				else if (sum < -COORD_SAT)
					sum = -COORD_SAT;
				axis[a] = sum;
				mag[a] = (sum < 0) ? -sum : sum;
			end
			dist_sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
			in_range = dist_sq <= {16'd0, range_sq};
			c = cos_half;
			if (c > Q_ONE)
				c = Q_ONE;
			if (c < -Q_ONE)
				c = -Q_ONE;
			cc = c * c;
			rest = 64'd268435456 - cc;
			xx = mag[0] * mag[0];
			yy = mag[1] * mag[1];
			lhs = xx * rest;
			rhs = yy * cc;
			if (c >= 0)
				in_angle = (axis[0] >= 0) && (lhs >= rhs);
			else
				in_angle = (axis[0] >= 0) || (lhs <= rhs);
			r.in_view = in_range && in_angle;
			r.kept_x = p.point_x;
			r.kept_y = p.point_y;
			r.kept_z = p.point_z;
			return r;
		endfunction

		function void note_point(point_t p);
			expected_q.insert(expected_q.size(), cull_point(p));
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (expected_q.size() == 0) begin
				if (errors < 10)
					$display("unexpected result transaction: in_view=%0b x=%0d y=%0d z=%0d",
						got.in_view, got.kept_x, got.kept_y, got.kept_z);
				errors++;
				return;
			end
			exp = expected_q[0];
			expected_q.delete(0);
			if (got.in_view !== exp.in_view || got.kept_x !== exp.kept_x ||
					got.kept_y !== exp.kept_y || got.kept_z !== exp.kept_z) begin
				if (errors < 10)
					$display({"mismatch: expected in_view=%0b x=%0d y=%0d z=%0d, ",
						"got in_view=%0b x=%0d y=%0d z=%0d"},
						exp.in_view, exp.kept_x, exp.kept_y, exp.kept_z,
						got.in_view, got.kept_x, got.kept_y, got.kept_z);
				errors++;
			end
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = CFG_ROT_ROW_X;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  point_valid  = 1'b0;
	logic                  point_stall;
	point_t                point        = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;

	fov_scoreboard sb = new();
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_left      = 0;

	point_fov_cull dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: check, then decide next cycle's stall
	initial begin
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				sb.check_result(result);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < sink_stall_pct);
			end
		end
	end

	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (point_valid && !point_stall) ||
					(result_valid && !result_stall))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("tb_point_fov_cull failed");
		$finish;
	end

	function automatic point_t point_at(int x, int y, int z);
		point_t p;
		p.point_x = x[23:0];
		p.point_y = y[23:0];
		p.point_z = z[23:0];
		return p;
	endfunction

	function automatic logic [23:0] coord_extreme();
		case ($urandom_range(4))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			default: return 24'h000001;
		endcase
	endfunction

	function automatic logic [23:0] coord_random();
		int bits;
		case ($urandom_range(9))
			0: return 24'($urandom);
			1: return coord_extreme();
			default: begin
				bits = $urandom_range(4, 18);
				return $signed(24'($urandom)) >>> (24 - bits);
			end
		endcase
	endfunction

	function automatic reg_set_t default_settings();
		reg_set_t v;
		v[CFG_ROT_ROW_X]      = 48'd16384;
		v[CFG_ROT_ROW_Y]      = 48'd16384 << 16;
		v[CFG_ROT_ROW_Z]      = 48'd16384 << 32;
		v[CFG_SHIFT_X]        = '0;
		v[CFG_SHIFT_Y]        = '0;
		v[CFG_SHIFT_Z]        = '0;
		v[CFG_RANGE_LIMIT_SQ] = 48'd10000000000;
		v[CFG_COS_HALF_FOV]   = 48'h0000_0000_C000;
		return v;
	endfunction

	function automatic reg_set_t random_settings(bit extreme);
		reg_set_t    v;
		logic [15:0] e;
		longint      r;
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 3; k++) begin
				if (extreme) begin
					case ($urandom_range(4))
						0: e = 16'h7FFF;
						1: e = 16'h8000;
						2: e = 16'h4000;
						3: e = 16'hC000;
						default: e = 16'h0000;
					endcase
				end else begin
					case ($urandom_range(3))
						0: e = 16'($urandom);
						1: e = 16'h0000;
						default: e = 16'($urandom_range(32768) - 16384);
					endcase
				end
				v[int'(CFG_ROT_ROW_X) + a][16*k +: 16] = e;
			end
			if (extreme)
				case ($urandom_range(3))
					0: v[int'(CFG_SHIFT_X) + a] = {16'($urandom), 32'h7FFF_FFFF};
					1: v[int'(CFG_SHIFT_X) + a] = {16'($urandom), 32'h8000_0000};
					default: v[int'(CFG_SHIFT_X) + a] = '0;
				endcase
			else if ($urandom_range(7) == 0)
				v[int'(CFG_SHIFT_X) + a] = {16'($urandom), 32'($urandom)};
			else
				v[int'(CFG_SHIFT_X) + a] =
					{16'($urandom), 32'($urandom_range(1 << 18) - (1 << 17))};
		end
		if (extreme) begin
			v[CFG_RANGE_LIMIT_SQ] = '1;
			case ($urandom_range(4))
				0: e = 16'h4000;
				1: e = 16'hC000;
				2: e = 16'h0000;
				3: e = 16'h7FFF;
				default: e = 16'h8000;
			endcase
		end else begin
			r = $urandom_range(1 << 18);
			v[CFG_RANGE_LIMIT_SQ] = ($urandom_range(5) == 0) ?
				{16'($urandom), 32'($urandom)} : 48'(r * r);
			e = ($urandom_range(5) == 0) ? 16'($urandom) :
				16'($urandom_range(32768) - 16384);
		end
		v[CFG_COS_HALF_FOV] = {32'($urandom), e};
		return v;
	endfunction

	task automatic apply_settings(input reg_set_t v);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= v[i];
			@(posedge clk);
			sb.set_reg(cfg_reg_t'(i), v[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_point(input point_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		do
			@(posedge clk);
		while (point_stall);
		sb.note_point(p);
	endtask

	task automatic settle_pipeline();
		point_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
	endtask

	task automatic run_phase(int n, int src_pct, int snk_pct, bit hold, bit pause);
		point_t p;
		src_idle_pct = src_pct;
		sink_stall_pct = snk_pct;
		if (hold)
			hold_left = 300;
		for (int i = 0; i < n; i++) begin
			if (pause && i == n / 2)
				settle_pipeline();
			p.point_x = coord_random();
			p.point_y = coord_random();
			p.point_z = coord_random();
			send_point(p);
		end
		settle_pipeline();
	endtask

	initial begin
		reg_set_t s;
		int       src_tbl [NUM_PHASES];
		int       snk_tbl [NUM_PHASES];
		src_tbl = '{0, 70, 0, 22, 0, 22};
		snk_tbl = '{0, 0, 70, 22, 0, 22};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: identity, 100 m, all bearings
		send_point(point_at(0, 0, 0));
		send_point(point_at(8388607, 8388607, 8388607));
		send_point(point_at(-8388608, -8388608, -8388608));
		send_point(point_at(100000, 0, 0));
		send_point(point_at(100001, 0, 0));
		send_point(point_at(-5000, 0, 0));
		send_point(point_at(0, -5000, 0));
		settle_pipeline();

		// half-scale x: rounding of halves, cosine clamped to one
		s = default_settings();
		s[CFG_ROT_ROW_X] = 48'd8192;
		s[CFG_RANGE_LIMIT_SQ] = '1;
		s[CFG_COS_HALF_FOV] = 48'hFFFF_FFFF_7FFF;
		apply_settings(s);
		send_point(point_at(1, 0, 0));
		send_point(point_at(-1, 0, 0));
		send_point(point_at(-3, 0, 0));
		send_point(point_at(4, 1, 0));
		send_point(point_at(8388607, 0, 5));
		send_point(point_at(-8388608, 0, 0));
		settle_pipeline();

		// far coordinates saturate
		s = default_settings();
		s[CFG_ROT_ROW_X] = {16'h8000, 16'h7FFF, 16'h7FFF};
		s[CFG_SHIFT_X] = 48'hABCD_7FFF_FFFF;
		s[CFG_SHIFT_Y] = 48'h0000_8000_0000;
		s[CFG_SHIFT_Z] = 48'h0000_7FFF_FFFF;
		s[CFG_RANGE_LIMIT_SQ] = '0;
		s[CFG_COS_HALF_FOV] = '0;
		apply_settings(s);
		send_point(point_at(8388607, 8388607, 8388607));
		send_point(point_at(-8388608, -8388608, -8388608));
		send_point(point_at(0, 0, 0));
		send_point(point_at(8388607, -8388608, 0));
		settle_pipeline();

		// wide view, negative cosine, behind-sensor points
		s = default_settings();
		s[CFG_SHIFT_X] = 48'hFFFF_FFFF_FFFB;
		s[CFG_COS_HALF_FOV] = 48'(-48'sd11585);
		apply_settings(s);
		send_point(point_at(5, 0, 0));
		send_point(point_at(-95, 99, 0));
		send_point(point_at(-95, 101, 0));
		send_point(point_at(0, -7, 0));
		settle_pipeline();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			apply_settings(random_settings(ph == 4));
			run_phase(PHASE_POINTS, src_tbl[ph], snk_tbl[ph], ph == 0, ph == 2 || ph == 3);
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb_point_fov_cull passed");
		else
			$display("tb_point_fov_cull failed");
		$finish;
	end

endmodule
